// ===== sv/vscl_pkg.sv =====
package vscl_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 64;
    localparam int CNT_W = 11;

    typedef struct packed {
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] new_value;
        logic                    force_req;
    } in_word_t;

    typedef struct packed {
        logic             written;
        logic [CNT_W-1:0] pending_count;
        logic [IDX_W-1:0] pending_head;
        logic [IDX_W-1:0] pending_tail;
        logic [CNT_W-1:0] permanent_count;
    } out_word_t;

    // append request from the lookup stage to one tracker
    typedef struct packed {
        logic             add;
        logic [IDX_W-1:0] idx;
    } trk_upd_t;

    // list state after the current update has been applied
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
    } trk_stat_t;

endpackage

// ===== sv/value_store_with_change_list_unit.sv =====
// Channel   Signals                      Word
// input     in_valid  / in_ready         in_data  (index, value, force)
// result    out_valid / out_ready        out_data (written, counts, head, tail)
// config    cfg_wr_en / cfg_wr_data      permanent_enable, no read-back
//
// Each item passes through ST_IDLE, which reads its entry from the store RAM, and
// ST_LOOKUP, which compares, writes back and updates both trackers; reads are registered.
// After reset the store is swept to zero, every entry in turn, with in_ready low.
// A result waiting in the output register does not block the next read; the
// write-back stage holds until that result is taken.
module value_store_with_change_list_unit #(
    parameter int ENTRY_COUNT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vscl_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vscl_pkg::out_word_t out_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);

    localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    typedef struct packed {
        logic                       main_listed;
        logic                       perm_listed;
        logic [vscl_pkg::VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [AW-1:0]        clr_addr_reg;
    logic [AW-1:0]        clr_addr_next;
    logic                 perm_en_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    vscl_pkg::out_word_t  out_data_reg;
    vscl_pkg::out_word_t  out_data_next;

    logic [vscl_pkg::IDX_W-1:0] idx_reg;
    logic [vscl_pkg::VAL_W-1:0] val_reg;
    logic                       force_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_entry;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_entry;

    logic                commit;
    logic                in_range;
    logic                changed;
    vscl_pkg::trk_upd_t  main_upd;
    vscl_pkg::trk_upd_t  perm_upd;
    vscl_pkg::trk_stat_t main_stat;
    vscl_pkg::trk_stat_t perm_stat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rd_en   = in_valid && in_ready;
    assign rd_addr = AW'(in_data.entry_index);

    assign commit   = (state_reg == ST_LOOKUP) && (!out_valid_reg || out_ready);
    assign in_range = 32'(idx_reg) < 32'(ENTRY_COUNT);
    assign changed  = in_range && ((rd_entry.value != val_reg) || force_reg);

    assign main_upd.add = commit && changed && !rd_entry.main_listed;
    assign main_upd.idx = idx_reg;
    assign perm_upd.add = commit && changed && perm_en_reg && !rd_entry.perm_listed;
    assign perm_upd.idx = idx_reg;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en    = 1'b1;
            wr_addr  = clr_addr_reg;
            wr_entry = '0;
        end
        else
        begin
            wr_en                = commit && changed;
            wr_addr              = AW'(idx_reg);
            wr_entry.main_listed = 1'b1;
            wr_entry.perm_listed = rd_entry.perm_listed || perm_en_reg;
            wr_entry.value       = val_reg;
        end
    end

    vscl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRY_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    vscl_tracker #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_main_trk (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (main_upd),
        .stat_next (main_stat)
    );

    vscl_tracker #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_perm_trk (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (perm_upd),
        .stat_next (perm_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(ENTRY_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold read data until the output register has room
                if (commit)
                begin
                    state_next                    = ST_IDLE;
                    out_valid_next                = 1'b1;
                    out_data_next.written         = changed;
                    out_data_next.pending_count   = main_stat.count;
                    out_data_next.pending_head    = main_stat.head;
                    out_data_next.pending_tail    = main_stat.tail;
                    out_data_next.permanent_count = perm_stat.count;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            perm_en_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            idx_reg   <= in_data.entry_index;
            val_reg   <= in_data.new_value;
            force_reg <= in_data.force_req;
        end
    end

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !wr_en)
        else $error("store written with no item in flight");
    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without a lookup");
    a_written_listed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.written |-> out_data_reg.pending_count != '0)
        else $error("written word but main list empty");
`endif

endmodule

// ===== sv/vscl_ram.sv =====
module vscl_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/vscl_tracker.sv =====
module vscl_tracker #(
    parameter int ENTRY_COUNT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vscl_pkg::trk_upd_t  upd,
    output vscl_pkg::trk_stat_t stat_next
);

    logic [vscl_pkg::CNT_W-1:0] count_reg;
    logic [vscl_pkg::CNT_W-1:0] count_next;
    logic [vscl_pkg::IDX_W-1:0] head_reg;
    logic [vscl_pkg::IDX_W-1:0] head_next;
    logic [vscl_pkg::IDX_W-1:0] tail_reg;
    logic [vscl_pkg::IDX_W-1:0] tail_next;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (upd.add)
        begin
            // empty list: the new word becomes the head as well
            if (count_reg == '0)
            begin
                head_next = upd.idx;
            end
            tail_next = upd.idx;
            if (32'(count_reg) < 32'(ENTRY_COUNT))
            begin
                count_next = count_reg + vscl_pkg::CNT_W'(1);
            end
        end
    end

    assign stat_next.count = count_next;
    assign stat_next.head  = head_next;
    assign stat_next.tail  = tail_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

`ifndef SYNTHESIS
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("tracker count went down");
    a_tail_follows_add: assert property (@(posedge clk) disable iff (!rst_n)
        upd.add |=> tail_reg == $past(upd.idx))
        else $error("tail not moved to appended index");
    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == '0 && tail_reg == '0)
        else $error("empty list has non-zero head or tail");
`endif

endmodule
